### rtl/lru_key_value_cache_macros.svh
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared property wrappers, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// same-cycle implication
`define LKV_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lkv: assertion failed");

// next-cycle implication
`define LKV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lkv: assertion failed");

`endif

### rtl/lkv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Field widths, register map and fixed codes.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 7;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // register index, taken from paddr[2]
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_SET = 1'b1;

    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

endpackage

### rtl/lkv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/lkv_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache register block
// APB capacity register and clamp to 1 .. the built entry count.
// ----------------------------------------------------------------------------
module lkv_regs import lkv_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [APB_AW-1:0]                   paddr,
    input  logic [APB_DW-1:0]                   pwdata,
    output logic [APB_DW-1:0]                   prdata,
    output logic                                pready,
    output logic [$clog2(ENTRIES+1)-1:0]        o_eff_cap
);

    localparam int CNTW = $clog2(ENTRIES + 1);
    localparam int XW = (CNTW > CAP_W) ? CNTW : CAP_W;

    logic [CAP_W-1:0] r_cap;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready && (paddr[2:2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (w_wr) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2:2] == REG_CAPACITY) begin
            prdata = APB_DW'(r_cap);
        end
    end

    always_comb begin
        if (r_cap == '0) begin
            o_eff_cap = CNTW'(1);
        end else if (XW'(r_cap) > XW'(ENTRIES)) begin
            o_eff_cap = CNTW'(ENTRIES);
        end else begin
            o_eff_cap = CNTW'(r_cap);
        end
    end

endmodule

### rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
//
// Input stream: s_axis_tuser = mode (0 get, 1 set), s_axis_tdata = key, value.
// Output stream: one item per get; m_axis_tuser = hit, m_axis_tdata = value
// (all ones on a miss). A set gives no output item.
// APB: one register, capacity, at address 0; clamped to 1 .. ENTRIES.
// Keys, values and recency ranks sit in three RAMs. One item is handled at
// a time: a scan reads every slot once through the key compare unit, then
// a second pass through the rank unit ages the ranks for a hit or a set,
// followed by a write-back. A get miss skips the ageing pass and the
// write-back. The next item is taken only once the current one is through;
// the sweep over the RAM read port sets that pace.
// The output register lets the next item be taken while a result waits;
// a get result stalls the block only while the previous one is still held.
// Reset clears all valid bits and occupancy, and sets capacity to 64.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache import lkv_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [KEY_W+VAL_W-1:0] s_axis_tdata,   // key, value
    input  logic [0:0]            s_axis_tuser,   // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [VAL_W-1:0]      m_axis_tdata,   // read_value
    output logic [0:0]            m_axis_tuser,   // hit
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNTW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_AGE,
        ST_FINISH,
        ST_OUT
    } t_state;

    t_state              r_state;
    logic                r_mode;
    logic [KEY_W-1:0]    r_key;
    logic [VAL_W-1:0]    r_val;
    logic [CNTW-1:0]     r_idx;
    logic                r_pv;
    logic [IW-1:0]       r_pidx;
    logic                r_found;
    logic [IW-1:0]       r_match;
    logic [IW-1:0]       r_mrank;
    logic                r_vfound;
    logic [IW-1:0]       r_vic;
    logic [IW-1:0]       r_vrank;
    logic                r_ffound;
    logic [IW-1:0]       r_free;
    logic [CNTW-1:0]     r_thr;
    logic [IW-1:0]       r_tgt;
    logic                r_touch;
    logic                r_ins;
    logic [ENTRIES-1:0]  r_valid;
    logic [CNTW-1:0]     r_occ;
    logic                r_ovld;
    logic                r_ohit;
    logic [VAL_W-1:0]    r_odata;

    logic [CNTW-1:0]     w_eff_cap;
    logic [KEY_W-1:0]    w_key_rd;
    logic [VAL_W-1:0]    w_val_rd;
    logic [IW-1:0]       w_rank_rd;
    logic                w_pvalid;
    logic                w_age_hit;
    logic                w_evict;
    logic                w_slot_ok;
    logic [IW-1:0]       w_slot;

    logic                w_key_we;
    logic                w_val_we;
    logic [IW-1:0]       w_val_waddr;
    logic                w_rank_we;
    logic [IW-1:0]       w_rank_waddr;
    logic [IW-1:0]       w_rank_wdata;

    lkv_regs #(
        .ENTRIES (ENTRIES)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_eff_cap (w_eff_cap)
    );

    lkv_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (r_tgt),
        .i_wdata (r_key),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_key_rd)
    );

    lkv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (w_val_waddr),
        .i_wdata (r_val),
        .i_raddr (r_match),
        .o_rdata (w_val_rd)
    );

    lkv_ram #(
        .WIDTH (IW),
        .DEPTH (ENTRIES)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (w_rank_we),
        .i_waddr (w_rank_waddr),
        .i_wdata (w_rank_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rank_rd)
    );

    assign w_pvalid  = r_valid[r_pidx];
    assign w_age_hit = r_pv && w_pvalid && (CNTW'(w_rank_rd) < r_thr);
    assign w_evict   = (r_occ >= w_eff_cap) && r_vfound;

    always_comb begin
        w_slot_ok = 1'b0;
        w_slot    = r_free;
        if (w_evict) begin
            w_slot_ok = 1'b1;
            w_slot    = (r_ffound && (r_free < r_vic)) ? r_free : r_vic;
        end else if (r_ffound) begin
            w_slot_ok = 1'b1;
        end
    end

    assign w_key_we    = (r_state == ST_FINISH) && r_ins;
    assign w_val_we    = ((r_state == ST_DECIDE) && (r_mode == MODE_SET) && r_found)
                       || ((r_state == ST_FINISH) && r_ins);
    assign w_val_waddr = (r_state == ST_DECIDE) ? r_match : r_tgt;

    assign w_rank_we    = ((r_state == ST_AGE) && w_age_hit)
                        || ((r_state == ST_FINISH) && (r_touch || r_ins));
    assign w_rank_waddr = (r_state == ST_FINISH) ? r_tgt : r_pidx;
    assign w_rank_wdata = (r_state == ST_FINISH) ? '0 : w_rank_rd + IW'(1);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tuser  = r_ohit;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_occ   <= '0;
            r_ovld  <= 1'b0;
            r_pv    <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (r_ovld && m_axis_tready && (r_state != ST_OUT)) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_mode   <= s_axis_tuser[0];
                        r_key    <= s_axis_tdata[KEY_W-1:0];
                        r_val    <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
                        r_idx    <= '0;
                        r_pv     <= 1'b0;
                        r_found  <= 1'b0;
                        r_vfound <= 1'b0;
                        r_ffound <= 1'b0;
                        r_state  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_idx != CNTW'(ENTRIES)) begin
                        r_idx  <= r_idx + CNTW'(1);
                        r_pv   <= 1'b1;
                        r_pidx <= r_idx[IW-1:0];
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        if (w_pvalid && (w_key_rd == r_key) && !r_found) begin
                            r_found <= 1'b1;
                            r_match <= r_pidx;
                            r_mrank <= w_rank_rd;
                        end
                        if (w_pvalid && (!r_vfound || (w_rank_rd >= r_vrank))) begin
                            r_vfound <= 1'b1;
                            r_vic    <= r_pidx;
                            r_vrank  <= w_rank_rd;
                        end
                        if (!w_pvalid && !r_ffound) begin
                            r_ffound <= 1'b1;
                            r_free   <= r_pidx;
                        end
                    end
                    if ((r_idx == CNTW'(ENTRIES)) && !r_pv) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_idx   <= '0;
                    r_touch <= r_found;
                    r_ins   <= !r_found && (r_mode == MODE_SET) && w_slot_ok;
                    if (r_found) begin
                        r_thr   <= CNTW'(r_mrank);
                        r_tgt   <= r_match;
                        r_state <= ST_AGE;
                    end else if (r_mode == MODE_GET) begin
                        r_state <= ST_OUT;
                    end else begin
                        if (w_evict) begin
                            r_valid[r_vic] <= 1'b0;
                            r_occ          <= r_occ - CNTW'(1);
                        end
                        if (w_slot_ok) begin
                            r_thr   <= CNTW'(ENTRIES);
                            r_tgt   <= w_slot;
                            r_state <= ST_AGE;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_AGE: begin
                    if (r_idx != CNTW'(ENTRIES)) begin
                        r_idx  <= r_idx + CNTW'(1);
                        r_pv   <= 1'b1;
                        r_pidx <= r_idx[IW-1:0];
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if ((r_idx == CNTW'(ENTRIES)) && !r_pv) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (r_ins) begin
                        r_valid[r_tgt] <= 1'b1;
                        r_occ          <= r_occ + CNTW'(1);
                    end
                    r_state <= (r_mode == MODE_GET) ? ST_OUT : ST_IDLE;
                end
                ST_OUT: begin
                    if (!r_ovld || m_axis_tready) begin
                        r_ovld  <= 1'b1;
                        r_ohit  <= r_found;
                        r_odata <= r_found ? w_val_rd : MISS_VALUE;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `LKV_ASSERT_NEXT(a_accept_starts_scan, s_axis_tvalid && s_axis_tready, (r_state == ST_SCAN) && (r_idx == '0))
    `LKV_ASSERT_IMPL(a_occ_matches_valid, r_state == ST_IDLE, $countones(r_valid) == int'(r_occ))
    `LKV_ASSERT_NEXT(a_insert_sets_valid, (r_state == ST_FINISH) && r_ins, r_valid[r_tgt])

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Streams get and set items into the cache under random idling on both
// sides. A shadow store with recency ranks predicts each get result. The
// capacity register is moved between phases over APB, from 0 to 127.
// ----------------------------------------------------------------------------
module tb_top;
    import lkv_pkg::*;

    localparam int ENTRIES     = 64;
    localparam int IDLE_PCT    = 27;
    localparam int SETTLE      = 2 * ENTRIES + 72;
    localparam int LIMIT       = 1_000_000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 90;
    localparam int POOL_N      = 96;

    localparam logic [APB_AW-1:0] CAP_ADDR      = {REG_CAPACITY, 2'b00};
    localparam logic [APB_AW-1:0] UNMAPPED_ADDR = {~REG_CAPACITY, 2'b00};

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } op_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value;
    } lookup_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [KEY_W+VAL_W-1:0] s_tdata  = '0;
    logic [0:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [VAL_W-1:0]       m_tdata;
    logic [0:0]             m_tuser;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // shadow store
    logic [KEY_W-1:0] st_key   [ENTRIES];
    logic [VAL_W-1:0] st_val   [ENTRIES];
    bit               st_valid [ENTRIES];
    int unsigned      st_rank  [ENTRIES];
    int unsigned      st_occ   = 0;
    logic [CAP_W-1:0] st_cap   = CAP_RESET;

    op_t     op_q [$];
    lookup_t lookup_q [$];
    op_t     cur_op;
    lookup_t got;
    lookup_t want;
    logic [KEY_W-1:0] key_pool [POOL_N];
    logic [CAP_W-1:0] phase_cap [PHASES] = '{7'd64, 7'd1, 7'd8, 7'd127, 7'd0,
                                             7'd3, 7'd16, 7'd65, 7'd2, 7'd64};

    bit calm = 1'b0;
    int n_queued   = 0;
    int n_accepted = 0;
    int n_sets     = 0;
    int n_hits     = 0;
    int n_misses   = 0;
    int n_writes   = 0;
    int n_fail     = 0;
    int n_cycles   = 0;

    always #4 i_clk = ~i_clk;

    lru_key_value_cache #(
        .ENTRIES(ENTRIES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .s_axis_tuser (s_tuser),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata),
        .m_axis_tuser (m_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    function automatic int unsigned cap_in_force();
        if (st_cap == 0) return 1;
        if (st_cap > ENTRIES) return ENTRIES;
        return st_cap;
    endfunction

    function automatic int find_slot(input logic [KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (st_valid[i] && st_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void promote(input int s);
        int unsigned r;
        r = st_rank[s];
        for (int i = 0; i < ENTRIES; i++)
            if (st_valid[i] && st_rank[i] < r) st_rank[i]++;
        st_rank[s] = 0;
    endfunction

    function automatic void evict_lru();
        int unsigned best;
        int victim;
        best = 0;
        victim = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (st_valid[i] && (victim < 0 || st_rank[i] >= best)) begin
                best = st_rank[i];
                victim = i;
            end
        end
        if (victim >= 0) begin
            st_valid[victim] = 1'b0;
            if (st_occ > 0) st_occ--;
        end
    endfunction

    function automatic void insert_pair(input logic [KEY_W-1:0] k,
                                        input logic [VAL_W-1:0] v);
        int slot;
        slot = -1;
        if (st_occ >= cap_in_force()) evict_lru();
        for (int i = 0; i < ENTRIES; i++) begin
            if (!st_valid[i] && slot < 0) slot = i;
        end
        if (slot < 0) return;
        for (int i = 0; i < ENTRIES; i++)
            if (st_valid[i]) st_rank[i]++;
        st_key[slot]   = k;
        st_val[slot]   = v;
        st_valid[slot] = 1'b1;
        st_rank[slot]  = 0;
        st_occ++;
    endfunction

    // returns 1 when the item gives a lookup result
    function automatic bit apply_op(input op_t op, output lookup_t res);
        int s;
        s = find_slot(op.key);
        res = '0;
        if (op.mode == MODE_GET) begin
            if (s >= 0) begin
                promote(s);
                res.hit   = 1'b1;
                res.value = st_val[s];
            end else begin
                res.hit   = 1'b0;
                res.value = MISS_VALUE;
            end
            return 1'b1;
        end
        if (s >= 0) begin
            st_val[s] = op.value;
            promote(s);
        end else begin
            insert_pair(op.key, op.value);
        end
        return 1'b0;
    endfunction

    task automatic queue_op(input logic mode, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] value);
        op_t op;
        op.mode  = mode;
        op.key   = key;
        op.value = value;
        op_q.push_back(op);
        n_queued++;
    endtask

    // wait until every item is taken and every lookup is back, then let a
    // trailing set finish its passes
    task automatic settle();
        while (n_accepted != n_queued || lookup_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr,
                             input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_CAPACITY) st_cap = data[CAP_W-1:0];
        n_writes++;
    endtask

    // item driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (apply_op(cur_op, got)) lookup_q.push_back(got);
                else n_sets++;
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (op_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_op = op_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_op.value, cur_op.key};
                    s_tuser  <= cur_op.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (lookup_q.size() == 0) begin
                    $error("unexpected item: hit %0b read_value %h", m_tuser[0], m_tdata);
                    n_fail++;
                end else begin
                    want = lookup_q.pop_front();
                    if (m_tuser[0] !== want.hit) begin
                        $error("hit: expected %0b, got %0b", want.hit, m_tuser[0]);
                        n_fail++;
                    end
                    if (m_tdata !== want.value) begin
                        $error("read_value: expected %h, got %h", want.value, m_tdata);
                        n_fail++;
                    end
                    if (want.hit) n_hits++;
                    else n_misses++;
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d lookups outstanding",
                     n_cycles, lookup_q.size());
            $display("** lru_key_value_cache: FAILED **");
            $finish;
        end
    end

    initial begin
        int unsigned eff;
        int unsigned pool_n;
        logic [KEY_W-1:0] k;

        for (int i = 0; i < POOL_N; i++) key_pool[i] = $urandom;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, extreme keys and values, overwrite, hits and misses
        queue_op(MODE_GET, 32'h0000_0000, 32'h1234_5678);
        queue_op(MODE_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_op(MODE_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_op(MODE_SET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_op(MODE_SET, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_op(MODE_GET, 32'h8000_0000, 32'h0000_0000);
        queue_op(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(MODE_SET, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
        queue_op(MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_op(MODE_GET, 32'h0000_0001, 32'h0000_0000);
        settle();

        // capacity below occupancy: inserts evict one each, nothing flushed
        apb_write(CAP_ADDR, 32'd2);
        queue_op(MODE_SET, 32'h0000_0001, 32'hA5A5_A5A5);
        queue_op(MODE_GET, 32'h0000_0000, 32'h0000_0000);
        queue_op(MODE_GET, 32'h0000_0001, 32'h0000_0000);
        settle();

        // zero acts as one
        apb_write(CAP_ADDR, 32'd0);
        queue_op(MODE_SET, 32'h0000_0002, 32'h0000_0003);
        queue_op(MODE_GET, 32'h8000_0000, 32'h0000_0000);
        queue_op(MODE_GET, 32'h0000_0002, 32'h0000_0000);
        settle();

        // unmapped register must leave capacity alone
        apb_write(UNMAPPED_ADDR, 32'd64);
        queue_op(MODE_SET, 32'h0000_0003, 32'h0000_0004);
        queue_op(MODE_GET, 32'h0000_0002, 32'h0000_0000);
        settle();

        // above the built size acts as the built size
        apb_write(CAP_ADDR, 32'd127);
        queue_op(MODE_SET, 32'h0000_0004, 32'h0000_0005);
        queue_op(MODE_GET, 32'h0000_0003, 32'h0000_0000);
        queue_op(MODE_GET, 32'h0000_0004, 32'h0000_0000);
        queue_op(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            apb_write(CAP_ADDR, {{(APB_DW-CAP_W){1'b0}}, phase_cap[p]});
            calm <= (p == 3);
            eff = cap_in_force();
            pool_n = eff + $urandom_range(1, eff / 2 + 3);
            if (pool_n > POOL_N) pool_n = POOL_N;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 9) == 0) k = $urandom;
                else k = key_pool[$urandom_range(0, pool_n - 1)];
                queue_op($urandom_range(0, 1) ? MODE_SET : MODE_GET, k, $urandom);
            end
            settle();
        end

        $display("%0d items: %0d sets, %0d gets (%0d hits, %0d misses)",
                 n_accepted, n_sets, n_hits + n_misses, n_hits, n_misses);
        $display("%0d register writes, capacity 0 to 127, lowered below occupancy",
                 n_writes);
        if (n_fail == 0) begin
            $display("** lru_key_value_cache: PASSED **");
        end else begin
            $display("** lru_key_value_cache: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/lkv_pkg.sv
rtl/lkv_ram.sv
rtl/lkv_regs.sv
rtl/lru_key_value_cache.sv
test/tb_top.sv
